>>> sv/ceb_pkg.sv
// Shared types and constants for the color expansion blit engine.
// Holds the register map, the register file layout and the pixel size codes.
// No dependencies.
package ceb_pkg;

	localparam int unsigned OFFSET_W = 28;
	localparam int unsigned COLOR_W  = 32;
	localparam int unsigned BPP_W    = 3;
	localparam int unsigned REG_IDX_W = 3;

	// Register indexes of the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROW_PITCH       = 3'd0,
		REG_BYTES_PER_PIXEL = 3'd1,
		REG_DEST_X          = 3'd2,
		REG_DEST_Y          = 3'd3,
		REG_RECT_WIDTH      = 3'd4,
		REG_FG_COLOR        = 3'd5,
		REG_BG_COLOR        = 3'd6,
		REG_OPAQUE_MODE     = 3'd7
	} reg_idx_t;

	// Pixel size codes that produce a frame-buffer write.
	localparam logic [BPP_W-1:0] BPP_1 = 3'd1;
	localparam logic [BPP_W-1:0] BPP_2 = 3'd2;
	localparam logic [BPP_W-1:0] BPP_4 = 3'd4;

	typedef struct packed {
		logic [14:0]        row_pitch;
		logic [BPP_W-1:0]   bytes_per_pixel;
		logic [11:0]        dest_x;
		logic [11:0]        dest_y;
		logic [12:0]        rect_width;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic               opaque_mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		row_pitch:       15'd0,
		bytes_per_pixel: BPP_4,
		dest_x:          12'd0,
		dest_y:          12'd0,
		rect_width:      13'd1,
		fg_color:        32'd0,
		bg_color:        32'd0,
		opaque_mode:     1'b0
	};

endpackage

>>> sv/color_expansion_blit.sv
// Top level of the color expansion blit engine: config registers, raster
// counters and a two-stage pixel pipeline. Depends on ceb_pkg and ceb_raster.
//
// Usage. Source pixels of a rectangle arrive row by row as words on the input
// channel (in_valid/in_ready, fields source_pixel and last_in_rect). Each
// accepted word advances the column and row counters; a word marked
// last_in_rect returns both to zero. A word produces one frame-buffer write
// on the output channel (out_valid/out_ready, fields byte_offset, write_data,
// write_bytes) when its pixel is set, or in opaque mode for any pixel, and
// only when bytes_per_pixel is 1, 2 or 4. Other words produce nothing.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data, which is
// always ready; they must only change while the pipeline is empty.
// Timing. The pipeline takes one word per cycle while it is not stalled. A write
// passes through stage one and then stage two, which drives the output:
// stage one registers the destination coordinates and color, stage two holds
// the offset built from one row-times-pitch multiply and an add. When the
// receiver stalls, stage two holds its write and stage one can still take one
// more word; in_ready drops only when both stages are full.
// Reset clears the registers to their defaults (four bytes per pixel, width
// one, all else zero), zeroes the counters and empties the pipeline.
module color_expansion_blit import ceb_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096,
	parameter int unsigned MAX_PITCH  = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	// source pixel channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          source_pixel,
	input  logic                 last_in_rect,
	// frame-buffer write channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OFFSET_W-1:0]  byte_offset,
	output logic [COLOR_W-1:0]   write_data,
	output logic [BPP_W-1:0]     write_bytes
);

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
	// Destination coordinates: a 12-bit origin plus a counter, one carry bit.
	localparam int unsigned XW = ((COL_W > 12) ? COL_W : 12) + 1;
	localparam int unsigned YW = ((ROW_W > 12) ? ROW_W : 12) + 1;
	localparam int unsigned PITCH_W = 15;
	localparam int unsigned PROD_W = YW + PITCH_W;
	localparam int unsigned SUM_W = (PROD_W > 30) ? PROD_W : 30;

	cfg_t cfg_q;

	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;

	logic in_accept;
	logic pixel_set;
	logic size_ok;
	logic in_writes;
	logic [COLOR_W-1:0] color_mask;
	logic [COLOR_W-1:0] color_in;
	logic [XW-1:0] x_in;
	logic [YW-1:0] y_in;
	logic [PITCH_W-1:0] pitch_eff;

	logic adv_s1;
	logic adv_s2;

	logic               valid_s1;
	logic [XW-1:0]      x_s1;
	logic [YW-1:0]      y_s1;
	logic [COLOR_W-1:0] data_s1;
	logic [BPP_W-1:0]   bytes_s1;

	logic [PROD_W-1:0]  row_base;
	logic [XW+1:0]      col_bytes;
	logic [SUM_W-1:0]   offset_sum;

	logic                valid_s2;
	logic [OFFSET_W-1:0] offset_s2;
	logic [COLOR_W-1:0]  data_s2;
	logic [BPP_W-1:0]    bytes_s2;

	// Configuration registers. The port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROW_PITCH:       cfg_q.row_pitch       <= cfg_data[14:0];
				REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_data[BPP_W-1:0];
				REG_DEST_X:          cfg_q.dest_x          <= cfg_data[11:0];
				REG_DEST_Y:          cfg_q.dest_y          <= cfg_data[11:0];
				REG_RECT_WIDTH:      cfg_q.rect_width      <= cfg_data[12:0];
				REG_FG_COLOR:        cfg_q.fg_color        <= cfg_data;
				REG_BG_COLOR:        cfg_q.bg_color        <= cfg_data;
				REG_OPAQUE_MODE:     cfg_q.opaque_mode     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow control. Stage two loads when it is empty or its write is
	// taken; stage one loads when it is empty or can move into stage two.
	assign adv_s2    = !valid_s2 || out_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign in_ready  = adv_s1;
	assign in_accept = in_valid && in_ready;

	// The counters step on every accepted word, whether it writes or not.
	ceb_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (in_accept),
		.last   (last_in_rect),
		.column (column),
		.row    (row)
	);

	// Decide whether this word writes, and pick and trim its color.
	assign pixel_set = |source_pixel;
	assign color_in  = pixel_set ? cfg_q.fg_color : cfg_q.bg_color;

	always_comb begin
		unique case (cfg_q.bytes_per_pixel)
			BPP_1: begin
				size_ok    = 1'b1;
				color_mask = 32'h0000_00FF;
			end
			BPP_2: begin
				size_ok    = 1'b1;
				color_mask = 32'h0000_FFFF;
			end
			BPP_4: begin
				size_ok    = 1'b1;
				color_mask = 32'hFFFF_FFFF;
			end
			default: begin
				// A three-byte or otherwise odd pixel size writes nothing.
				size_ok    = 1'b0;
				color_mask = 32'h0000_0000;
			end
		endcase
	end

	assign in_writes = size_ok && (pixel_set || cfg_q.opaque_mode);

	assign x_in = XW'(cfg_q.dest_x) + XW'(column);
	assign y_in = YW'(cfg_q.dest_y) + YW'(row);

	// Stage one: coordinates, color and pixel size of a word that writes.
	// Words that write nothing leave the stage empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_accept && in_writes;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_accept) begin
			x_s1     <= x_in;
			y_s1     <= y_in;
			data_s1  <= color_in & color_mask;
			bytes_s1 <= cfg_q.bytes_per_pixel;
		end
	end

	// Pitch values above the maximum behave as the maximum.
	assign pitch_eff = ({2'b00, cfg_q.row_pitch} > 17'(MAX_PITCH)) ?
		PITCH_W'(MAX_PITCH) : cfg_q.row_pitch;

	// Byte offset: row times pitch plus column times pixel size. The pixel
	// size is a power of two here, so the column term is a shift.
	assign row_base = PROD_W'(y_s1) * PROD_W'(pitch_eff);

	always_comb begin
		unique case (bytes_s1)
			BPP_2:   col_bytes = (XW+2)'(x_s1) << 1;
			BPP_4:   col_bytes = (XW+2)'(x_s1) << 2;
			default: col_bytes = (XW+2)'(x_s1);
		endcase
	end

	assign offset_sum = SUM_W'(row_base) + SUM_W'(col_bytes);

	// Stage two: the finished write, held until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			offset_s2 <= offset_sum[OFFSET_W-1:0];
			data_s2   <= data_s1;
			bytes_s2  <= bytes_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign byte_offset = offset_s2;
	assign write_data  = data_s2;
	assign write_bytes = bytes_s2;

`ifndef SYNTHESIS
	a_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> write_bytes == BPP_1 || write_bytes == BPP_2 || write_bytes == BPP_4)
		else $error("write issued with an unsupported pixel size");

	a_byte_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_bytes == BPP_1 |-> write_data[31:8] == 24'd0)
		else $error("one-byte write carries data above its byte");

	a_half_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_bytes == BPP_2 |-> write_data[31:16] == 16'd0)
		else $error("two-byte write carries data above its halfword");
`endif

endmodule

>>> sv/ceb_raster.sv
// Column and row counters that walk the destination rectangle.
// Depends on ceb_pkg for the register file layout.
module ceb_raster import ceb_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096,
	localparam int unsigned COL_W = $clog2(MAX_WIDTH),
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step,
	input  logic             last,
	output logic [COL_W-1:0] column,
	output logic [ROW_W-1:0] row
);

	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0]      width_req;
	logic [COL_W:0]   width_eff;
	logic [COL_W:0]   col_next;
	logic [ROW_W:0]   row_next;
	logic             col_wrap;
	logic             row_wrap;

	// A width of zero behaves as one; widths above the maximum are clamped.
	assign width_req = 16'(cfg.rect_width);

	always_comb begin
		priority if (width_req == 16'd0) begin
			width_eff = (COL_W+1)'(1);
		end else if (width_req > 16'(MAX_WIDTH)) begin
			width_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			width_eff = (COL_W+1)'(width_req);
		end
	end

	assign col_next = {1'b0, column_q} + (COL_W+1)'(1);
	assign row_next = {1'b0, row_q} + (ROW_W+1)'(1);
	assign col_wrap = (col_next >= width_eff);
	assign row_wrap = (row_next >= (ROW_W+1)'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (step) begin
			if (last) begin
				column_q <= '0;
				row_q    <= '0;
			end else if (col_wrap) begin
				column_q <= '0;
				row_q    <= row_wrap ? '0 : row_next[ROW_W-1:0];
			end else begin
				column_q <= col_next[COL_W-1:0];
			end
		end
	end

	assign column = column_q;
	assign row    = row_q;

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> column_q == '0 && row_q == '0)
		else $error("raster counters not cleared after last pixel");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(column_q) && $stable(row_q))
		else $error("raster counters moved without a pixel");

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last && col_wrap |=> column_q == '0)
		else $error("column counter not cleared at the end of a row");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the color expansion blit engine.
// Drives source pixel words and register writes, and predicts every frame-buffer write.
// Depends on ceb_pkg and color_expansion_blit.
module testbench import ceb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_W = 4096;
	localparam int unsigned MAX_H = 4096;
	localparam int unsigned MAX_P = 16384;

	// The engine has two stages; the settle time below also covers words that write nothing.
	localparam int unsigned PIPE_SETTLE = 4;
	localparam int unsigned RANDOM_WORDS = 2000;

	// One frame-buffer write as it leaves the engine.
	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [COLOR_W-1:0]  data;
		logic [BPP_W-1:0]    nbytes;
	} fb_write_t;

	// How a directed pixel word is checked: against the predictor, as a word
	// that must write nothing, or against the write typed into the row.
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WRITE} chk_t;
	typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		reg_idx_t  idx;
		logic [31:0] value;
		logic        last;
		chk_t        chk;
		fb_write_t   lit;
	} step_row_t;

	// Directed stimulus. Register rows carry the register and its value; pixel
	// rows carry the source pixel, the end mark and, where it is obvious, the write.
	localparam step_row_t DIRECTED [40] = '{
		// Reset values: zero pitch, four bytes, width one, black, transparent.
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0000, 1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0001, 1'b0, CHK_WRITE,
			'{28'd0, 32'h0, 3'd4}},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'hFFFF_FFFF, 1'b1, CHK_WRITE,
			'{28'd0, 32'h0, 3'd4}},
		// Largest legal geometry, single byte pixels, opaque.
		'{ROW_REG, REG_ROW_PITCH,       32'd16384,     1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_BYTES_PER_PIXEL, 32'd1,         1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_DEST_X,          32'd4095,      1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_DEST_Y,          32'd4095,      1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_RECT_WIDTH,      32'd4096,      1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_FG_COLOR,        32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_BG_COLOR,        32'hA5A5_A5A5, 1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_OPAQUE_MODE,     32'd1,         1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h8000_0000, 1'b0, CHK_WRITE,
			'{28'd67096575, 32'hFF, 3'd1}},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0000, 1'b0, CHK_WRITE,
			'{28'd67096576, 32'hA5, 3'd1}},
		'{ROW_REG, REG_BYTES_PER_PIXEL, 32'd2, 1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0001, 1'b0, CHK_WRITE,
			'{28'd67100674, 32'hFFFF, 3'd2}},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0000, 1'b1, CHK_WRITE,
			'{28'd67100676, 32'hA5A5, 3'd2}},
		// Pixel sizes that write nothing, set and clear pixels alike.
		'{ROW_REG, REG_BYTES_PER_PIXEL, 32'd3, 1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0001, 1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_BYTES_PER_PIXEL, 32'd0, 1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0000, 1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_BYTES_PER_PIXEL, 32'd7, 1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0001, 1'b1, CHK_NONE, '0},
		// Width zero behaves as one, pitch past the maximum is clamped.
		'{ROW_REG, REG_BYTES_PER_PIXEL, 32'd4,     1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_RECT_WIDTH,      32'd0,     1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_ROW_PITCH,       32'd32767, 1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_DEST_X,          32'd0,     1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_DEST_Y,          32'd0,     1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0001, 1'b0, CHK_WRITE,
			'{28'd0, 32'hFFFF_FFFF, 3'd4}},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0010, 1'b0, CHK_WRITE,
			'{28'd16384, 32'hFFFF_FFFF, 3'd4}},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0000, 1'b1, CHK_WRITE,
			'{28'd32768, 32'hA5A5_A5A5, 3'd4}},
		// Width above the maximum is clamped; transparent mode skips clear pixels.
		'{ROW_REG, REG_RECT_WIDTH,  32'd8191,      1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_OPAQUE_MODE, 32'd0,         1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_FG_COLOR,    32'h1234_5678, 1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_DEST_X,      32'd4095,      1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_DEST_Y,      32'd4095,      1'b0, CHK_NONE, '0},
		'{ROW_REG, REG_ROW_PITCH,   32'd16384,     1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0000, 1'b0, CHK_NONE, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h0000_0002, 1'b0, CHK_WRITE,
			'{28'd67108864, 32'h1234_5678, 3'd4}},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h7FFF_FFFF, 1'b0, CHK_MODEL, '0},
		'{ROW_PIXEL, REG_ROW_PITCH, 32'h5555_5555, 1'b1, CHK_MODEL, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [31:0]          source_pixel;
	logic                 last_in_rect;
	logic                 out_valid;
	logic                 out_ready;
	logic [OFFSET_W-1:0]  byte_offset;
	logic [COLOR_W-1:0]   write_data;
	logic [BPP_W-1:0]     write_bytes;

	// Predictor state: a copy of the register file and the raster counters.
	cfg_t        regs_model;
	logic [11:0] col_now;
	logic [11:0] row_now;

	// Writes predicted for accepted words, oldest first.
	fb_write_t writes_due[$];

	// Largest idle gap the sender draws before each word and the receiver before each write.
	int unsigned gap_max;
	int unsigned stall_max;

	int unsigned words_sent;
	int unsigned writes_seen;
	int unsigned reg_writes;
	int unsigned mismatch_count;

	color_expansion_blit #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H),
		.MAX_PITCH (MAX_P)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.source_pixel(source_pixel),
		.last_in_rect(last_in_rect),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_offset (byte_offset),
		.write_data  (write_data),
		.write_bytes (write_bytes)
	);

	always #5 clk = ~clk;

	// Effective rectangle width: zero counts as one and anything past the
	// maximum is clamped.
	function automatic int unsigned span_now();
		int unsigned w;
		w = regs_model.rect_width;
		if (w == 0) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	// Works out the write that one source word causes, if any, and then moves
	// the raster counters on exactly as the engine does.
	function automatic bit expand_pixel(input logic [31:0] pix, input logic last,
			output fb_write_t wr);
		bit is_set;
		bit emits;
		logic [31:0] color;
		logic [31:0] size_mask;
		longint unsigned pitch;
		longint unsigned x;
		longint unsigned y;
		int unsigned col_next;
		int unsigned row_next;
		is_set = (pix != 32'd0);
		emits = is_set || regs_model.opaque_mode;
		color = is_set ? regs_model.fg_color : regs_model.bg_color;
		case (regs_model.bytes_per_pixel)
			BPP_1: size_mask = 32'h0000_00FF;
			BPP_2: size_mask = 32'h0000_FFFF;
			BPP_4: size_mask = 32'hFFFF_FFFF;
			default: begin
				size_mask = 32'd0;
				emits = 1'b0;
			end
		endcase
		pitch = regs_model.row_pitch;
		if (pitch > MAX_P) pitch = MAX_P;
		x = longint'(regs_model.dest_x) + longint'(col_now);
		y = longint'(regs_model.dest_y) + longint'(row_now);
		wr.offset = OFFSET_W'(x * regs_model.bytes_per_pixel + y * pitch);
		wr.data = color & size_mask;
		wr.nbytes = regs_model.bytes_per_pixel;

		if (last) begin
			col_now = '0;
			row_now = '0;
		end else begin
			col_next = int'(col_now) + 1;
			row_next = int'(row_now);
			if (col_next >= span_now()) begin
				col_next = 0;
				row_next++;
				if (row_next >= MAX_H) row_next = 0;
			end
			col_now = 12'(col_next);
			row_now = 12'(row_next);
		end
		return emits;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at write %0d: %s expected 0x%0h, got 0x%0h",
				writes_seen, what, want, got);
	endtask

	// Waits until every predicted write has been taken, then gives the two
	// stages time to flush words that write nothing. The sender is idle meanwhile.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (writes_due.size() != 0) @(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	// Register writes only ever happen with the pipeline empty.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ROW_PITCH:       regs_model.row_pitch = data[14:0];
			REG_BYTES_PER_PIXEL: regs_model.bytes_per_pixel = data[BPP_W-1:0];
			REG_DEST_X:          regs_model.dest_x = data[11:0];
			REG_DEST_Y:          regs_model.dest_y = data[11:0];
			REG_RECT_WIDTH:      regs_model.rect_width = data[12:0];
			REG_FG_COLOR:        regs_model.fg_color = data;
			REG_BG_COLOR:        regs_model.bg_color = data;
			REG_OPAQUE_MODE:     regs_model.opaque_mode = data[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sends one source word. The sender first idles for a random number of
	// cycles; with no idle cycle, valid simply stays high for the next word.
	// Once the word is taken, its expected write (if any) is queued.
	task automatic drive_pixel(input logic [31:0] pix, input logic last,
			input chk_t chk, input fb_write_t lit);
		int unsigned gap;
		fb_write_t predicted;
		bit produced;
		gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		source_pixel <= pix;
		last_in_rect <= last;
		do @(posedge clk); while (!in_ready);
		produced = expand_pixel(pix, last, predicted);
		case (chk)
			CHK_MODEL: if (produced) writes_due.push_back(predicted);
			CHK_WRITE: writes_due.push_back(lit);
			default: ;
		endcase
		words_sent++;
	endtask

	// Clear pixels, single set bits and fully random values.
	function automatic logic [31:0] random_pixel();
		case ($urandom_range(0, 4))
			0, 1: return 32'd0;
			2: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// One random phase: a fresh random register setting, then whole rectangles
	// of random content. Now and then a rectangle loses its end mark or gets a
	// stray one, and now and then the sender waits for the pipeline to empty.
	task automatic random_phase(input int unsigned n_words);
		logic [31:0] data;
		int unsigned pick;
		int unsigned rect_len;
		int unsigned left;
		logic last;

		data = $urandom;
		case ($urandom_range(0, 3))
			0: data[14:0] = '0;
			1: data[14:0] = 15'(MAX_P);
			2: data[14:0] = 15'($urandom_range(MAX_P + 1, 32767));
			default: data[14:0] = 15'($urandom_range(1, 2048));
		endcase
		write_reg(REG_ROW_PITCH, data);

		data = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 3) data[BPP_W-1:0] = BPP_1;
		else if (pick < 5) data[BPP_W-1:0] = BPP_2;
		else if (pick < 8) data[BPP_W-1:0] = BPP_4;
		else data[BPP_W-1:0] = BPP_W'($urandom_range(0, 7));
		write_reg(REG_BYTES_PER_PIXEL, data);

		data = $urandom;
		pick = $urandom_range(0, 3);
		if (pick == 0) data[11:0] = '0;
		else if (pick == 1) data[11:0] = '1;
		write_reg(REG_DEST_X, data);

		data = $urandom;
		pick = $urandom_range(0, 3);
		if (pick == 0) data[11:0] = '0;
		else if (pick == 1) data[11:0] = '1;
		write_reg(REG_DEST_Y, data);

		data = $urandom;
		case ($urandom_range(0, 9))
			0: data[12:0] = '0;
			1: data[12:0] = 13'(MAX_W);
			2: data[12:0] = 13'($urandom_range(MAX_W + 1, 8191));
			default: data[12:0] = 13'($urandom_range(1, 12));
		endcase
		write_reg(REG_RECT_WIDTH, data);

		write_reg(REG_FG_COLOR, $urandom);
		write_reg(REG_BG_COLOR, $urandom);
		write_reg(REG_OPAQUE_MODE, $urandom);

		// Some phases run back to back on both sides.
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
		stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;

		left = n_words;
		while (left > 0) begin
			rect_len = span_now() * $urandom_range(1, 4);
			if (rect_len > 48) rect_len = 48;
			for (int unsigned k = 0; k < rect_len && left > 0; k++) begin
				last = (k == rect_len - 1);
				if ($urandom_range(0, 19) == 0) last = ~last;
				if ($urandom_range(0, 63) == 0) drain_pipeline();
				drive_pixel(random_pixel(), last, CHK_MODEL, '0);
				left--;
			end
		end
	endtask

	// Receiver: before each write it holds ready low for a random number of
	// cycles, then keeps it high until a write is taken.
	initial begin : fb_receiver
		int unsigned hold;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Scoreboard: every write the engine hands over must match the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		fb_write_t want;
		if (arst_n && out_valid && out_ready) begin
			writes_seen++;
			if (writes_due.size() == 0) begin
				report_mismatch("unexpected write, offset", 32'd0, 32'(byte_offset));
			end else begin
				want = writes_due.pop_front();
				if (byte_offset !== want.offset)
					report_mismatch("byte_offset", 32'(want.offset), 32'(byte_offset));
				if (write_data !== want.data)
					report_mismatch("write_data", want.data, write_data);
				if (write_bytes !== want.nbytes)
					report_mismatch("write_bytes", 32'(want.nbytes), 32'(write_bytes));
			end
		end
	end

	initial begin : stimulus
		int unsigned random_sent;
		int unsigned phases;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROW_PITCH;
		cfg_data = '0;
		in_valid = 1'b0;
		source_pixel = '0;
		last_in_rect = 1'b0;
		regs_model = CFG_RESET;
		col_now = '0;
		row_now = '0;
		gap_max = 14;
		stall_max = 14;
		words_sent = 0;
		writes_seen = 0;
		reg_writes = 0;
		mismatch_count = 0;
		random_sent = 0;
		phases = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: register rows go through the write port with the
		// pipeline empty, pixel rows are sent as words.
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_REG)
				write_reg(DIRECTED[i].idx, DIRECTED[i].value);
			else
				drive_pixel(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].chk,
					DIRECTED[i].lit);
		end

		// Random phases until the random word budget is spent.
		while (random_sent < RANDOM_WORDS) begin
			random_phase($urandom_range(60, 140));
			random_sent = words_sent - 17;
			phases++;
		end

		// Let the last writes out, then watch a little longer for strays.
		drain_pipeline();
		repeat (16) @(negedge clk);
		if (writes_due.size() != 0)
			report_mismatch("writes never produced", writes_due.size(), 0);

		$display("Sent %0d source words over %0d random phases and %0d register writes.",
			words_sent, phases, reg_writes);
		$display("Checked %0d frame-buffer writes, %0d mismatches.",
			writes_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("[color_expansion_blit] OK");
		end else begin
			$display("[color_expansion_blit] ERROR");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("Timed out waiting on the engine.");
		$display("[color_expansion_blit] ERROR");
		$finish;
	end

endmodule
